### rtl/erm_pkg.sv
package erm_pkg;

  localparam int TRIG_BITS = 16;
  localparam int TRIG_W    = TRIG_BITS + 2;
  localparam int ANGLE_W   = 16;
  localparam int VEC_W     = 32;
  localparam int LIMIT_W   = 15;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd33;

  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_W     = 34;
  localparam int CORDIC_FRAC  = 30;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
    32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  localparam int PROD_W = VEC_W + TRIG_W;
  localparam int WIDE_W = TRIG_BITS + 38;
  localparam int QUO_W  = TRIG_BITS + 33;
  localparam int DIV_W  = TRIG_BITS + 1;
  localparam int CR_W   = VEC_W + 2;
  localparam int MAG_W  = TRIG_BITS + 34;

  localparam logic signed [WIDE_W-1:0] ROUND_HALF = WIDE_W'(1) <<< (TRIG_BITS - 1);
  localparam logic signed [VEC_W-1:0] VEC_POS_MAX = 32'sh7fff_ffff;
  localparam logic signed [VEC_W-1:0] VEC_NEG_MAX = 32'sh8000_0000;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic signed [VEC_W-1:0] v;
    logic                    sat;
  } clamp_t;

  typedef struct packed {
    logic                     mode;
    logic                     sing;
    logic signed [TRIG_W-1:0] s_pit;
    logic signed [TRIG_W-1:0] c_pit;
    logic signed [TRIG_W-1:0] s_yaw;
    logic signed [TRIG_W-1:0] c_yaw;
    logic signed [VEC_W-1:0]  a;
    logic signed [VEC_W-1:0]  b;
    logic signed [VEC_W-1:0]  c;
  } q_item_t;

  function automatic logic signed [WIDE_W-1:0] round_q(input logic signed [WIDE_W-1:0] v);
    return (v + ROUND_HALF) >>> TRIG_BITS;
  endfunction

  function automatic clamp_t clamp32(input logic signed [WIDE_W-1:0] v);
    clamp_t r;
    if (v > WIDE_W'(VEC_POS_MAX)) begin
      r.v   = VEC_POS_MAX;
      r.sat = 1'b1;
    end else if (v < WIDE_W'(VEC_NEG_MAX)) begin
      r.v   = VEC_NEG_MAX;
      r.sat = 1'b1;
    end else begin
      r.v   = v[VEC_W-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

### rtl/erm_if.sv
interface erm_in_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic [erm_pkg::ANGLE_W-1:0]         pitch_angle;
  logic [erm_pkg::ANGLE_W-1:0]         yaw_angle;
  logic signed [erm_pkg::VEC_W-1:0]    in_x;
  logic signed [erm_pkg::VEC_W-1:0]    in_y;
  logic signed [erm_pkg::VEC_W-1:0]    in_z;
  modport source (output valid, mode, pitch_angle, yaw_angle, in_x, in_y, in_z,
                  input ready);
  modport sink (input valid, mode, pitch_angle, yaw_angle, in_x, in_y, in_z,
                output ready);
endinterface

interface erm_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [erm_pkg::VEC_W-1:0] out_x;
  logic signed [erm_pkg::VEC_W-1:0] out_y;
  logic signed [erm_pkg::VEC_W-1:0] out_z;
  logic                             singular;
  logic                             saturated;
  modport source (output valid, out_x, out_y, out_z, singular, saturated, input ready);
  modport sink (input valid, out_x, out_y, out_z, singular, saturated, output ready);
endinterface

interface erm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [erm_pkg::LIMIT_W-1:0]   data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### rtl/euler_rpy_rate_map.sv
// Roll-pitch-yaw rate kinematics, one transaction in and one out per cycle sustained
// while rsp.ready holds. The path is 32 stages of pitch/yaw CORDIC, a classify stage,
// the two-entry queue, and a back pipeline whose length is set by the restoring
// divider for the roll-rate quotient (TRIG_BITS + 33 stages, one bit each).
// rst is synchronous, active high: it empties all pipelines and the queue and sets
// min_cos_limit to 33; data registers are not reset.
module euler_rpy_rate_map (
  input  logic      clk,
  input  logic      rst,
  erm_in_if.sink    cmd,
  erm_out_if.source rsp,
  erm_cfg_if.sink   cfg
);
  // configuration register: always ready; the user must write it only while idle, the block does not enforce this
  logic [erm_pkg::LIMIT_W-1:0] min_cos_limit;

  // front to queue, queue to back
  erm_pkg::q_item_t f_item, b_item;
  logic f_valid, f_ready;
  logic b_valid, b_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_cos_limit <= erm_pkg::LIMIT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      min_cos_limit <= cfg.data;
    end
  end

  // front: accept a transaction, run sine/cosine of both angles, flag singular pitch
  erm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .min_cos_limit(min_cos_limit),
    .item         (f_item),
    .item_valid   (f_valid),
    .item_ready   (f_ready)
  );

  // short queue so the front keeps taking transactions while the back stalls, until the queue is full
  erm_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_item (f_item),
    .wr_valid(f_valid),
    .wr_ready(f_ready),
    .rd_item (b_item),
    .rd_valid(b_valid),
    .rd_ready(b_ready)
  );

  // back: products, divide by cos(pitch), rounding, saturation, output register
  erm_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q      (b_item),
    .q_valid(b_valid),
    .q_ready(b_ready),
    .rsp    (rsp)
  );
endmodule

### rtl/erm_cordic.sv
module erm_cordic (
  input  logic                              clk,
  input  logic                              advance,
  input  logic [erm_pkg::ANGLE_W-1:0]       angle,
  output logic signed [erm_pkg::TRIG_W-1:0] sin_q,
  output logic signed [erm_pkg::TRIG_W-1:0] cos_q
);
  localparam int N     = erm_pkg::CORDIC_STEPS;
  localparam int W     = erm_pkg::CORDIC_W;
  localparam int TW    = erm_pkg::TRIG_W;
  localparam int SHIFT = erm_pkg::CORDIC_FRAC - erm_pkg::TRIG_BITS;
  localparam logic signed [W-1:0] HALF = W'(1) <<< (SHIFT - 1);
  localparam logic signed [W-1:0] ONE  = W'(1) <<< erm_pkg::TRIG_BITS;

  logic [31:0] ph, ph_test, ph_rot;
  logic        flip_in;
  logic signed [W-1:0] x [N+1];
  logic signed [W-1:0] y [N+1];
  logic signed [W-1:0] z [N+1];
  logic                flip [N+1];
  logic signed [W-1:0] xf, yf, xr, yr, xc, yc;

  // fold the angle into the right half plane
  always_comb begin
    ph      = {angle, 16'h0000};
    ph_test = ph + 32'h4000_0000;
    flip_in = ph_test[31];
    ph_rot  = flip_in ? (ph ^ 32'h8000_0000) : ph;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      x[0]    <= erm_pkg::CORDIC_GAIN;
      y[0]    <= '0;
      z[0]    <= {{(W-32){ph_rot[31]}}, ph_rot};
      flip[0] <= flip_in;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [W-1:0] atan_i;
    assign atan_i = {{(W-32){1'b0}}, erm_pkg::ATAN_TURNS[i]};
    always_ff @(posedge clk) begin
      if (advance) begin
        flip[i+1] <= flip[i];
        if (!z[i][W-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - atan_i;
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + atan_i;
        end
      end
    end
  end

  // undo the fold, round to trig precision, clamp to +-1.0
  always_comb begin
    xf = flip[N] ? -x[N] : x[N];
    yf = flip[N] ? -y[N] : y[N];
    xr = (xf + HALF) >>> SHIFT;
    yr = (yf + HALF) >>> SHIFT;
    xc = (xr > ONE) ? ONE : ((xr < -ONE) ? -ONE : xr);
    yc = (yr > ONE) ? ONE : ((yr < -ONE) ? -ONE : yr);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cos_q <= xc[TW-1:0];
      sin_q <= yc[TW-1:0];
    end
  end
endmodule

### rtl/erm_front.sv
module erm_front (
  input  logic                         clk,
  input  logic                         rst,
  erm_in_if.sink                       cmd,
  input  logic [erm_pkg::LIMIT_W-1:0]  min_cos_limit,
  output erm_pkg::q_item_t             item,
  output logic                         item_valid,
  input  logic                         item_ready
);
  localparam int LAT   = erm_pkg::CORDIC_STEPS + 2;
  localparam int TB    = erm_pkg::TRIG_BITS;
  localparam int TW    = erm_pkg::TRIG_W;
  localparam int CMP_W = TW - 1 + erm_pkg::LIMIT_W;

  logic advance;
  logic [LAT-1:0] vld;
  logic mode_d [LAT];
  logic signed [erm_pkg::VEC_W-1:0] a_d [LAT];
  logic signed [erm_pkg::VEC_W-1:0] b_d [LAT];
  logic signed [erm_pkg::VEC_W-1:0] c_d [LAT];
  logic signed [TW-1:0] s_pit, c_pit, s_yaw, c_yaw;
  logic signed [TW-1:0] mag_c;
  logic [CMP_W-1:0] lhs, rhs;
  logic sing;

  assign advance   = !item_valid || item_ready;
  assign cmd.ready = advance;

  erm_cordic u_pitch (.clk(clk), .advance(advance), .angle(cmd.pitch_angle),
                      .sin_q(s_pit), .cos_q(c_pit));
  erm_cordic u_yaw (.clk(clk), .advance(advance), .angle(cmd.yaw_angle),
                    .sin_q(s_yaw), .cos_q(c_yaw));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld        <= '0;
      item_valid <= 1'b0;
    end else if (advance) begin
      vld        <= {vld[LAT-2:0], cmd.valid};
      item_valid <= vld[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mode_d[0] <= cmd.mode;
      a_d[0]    <= cmd.in_x;
      b_d[0]    <= cmd.in_y;
      c_d[0]    <= cmd.in_z;
      for (int k = 1; k < LAT; k++) begin
        mode_d[k] <= mode_d[k-1];
        a_d[k]    <= a_d[k-1];
        b_d[k]    <= b_d[k-1];
        c_d[k]    <= c_d[k-1];
      end
    end
  end

  // singular test (mode 0 only): |cos(pitch)| * 2^15 < limit * 2^TRIG_BITS, or a zero cosine
  always_comb begin
    mag_c = c_pit[TW-1] ? -c_pit : c_pit;
    lhs   = {mag_c[TW-2:0], {erm_pkg::LIMIT_W{1'b0}}};
    rhs   = {1'b0, min_cos_limit, {TB{1'b0}}};
    sing  = !mode_d[LAT-1] && ((c_pit == '0) || (lhs < rhs));
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      item.mode  <= mode_d[LAT-1];
      item.sing  <= sing;
      item.s_pit <= s_pit;
      item.c_pit <= c_pit;
      item.s_yaw <= s_yaw;
      item.c_yaw <= c_yaw;
      item.a     <= a_d[LAT-1];
      item.b     <= b_d[LAT-1];
      item.c     <= c_d[LAT-1];
    end
  end
endmodule

### rtl/erm_fifo.sv
module erm_fifo (
  input  logic             clk,
  input  logic             rst,
  input  erm_pkg::q_item_t wr_item,
  input  logic             wr_valid,
  output logic             wr_ready,
  output erm_pkg::q_item_t rd_item,
  output logic             rd_valid,
  input  logic             rd_ready
);
  localparam int DEPTH = erm_pkg::FIFO_DEPTH;
  localparam int AW    = erm_pkg::FIFO_AW;

  erm_pkg::q_item_t mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   count;
  logic push, pop;

  assign wr_ready = count != (AW+1)'(DEPTH);
  assign rd_valid = count != '0;
  assign rd_item  = mem[rp];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH))
    else $error("queue count exceeds depth");
endmodule

### rtl/erm_back.sv
module erm_back (
  input  logic             clk,
  input  logic             rst,
  input  erm_pkg::q_item_t q,
  input  logic             q_valid,
  output logic             q_ready,
  erm_out_if.source        rsp
);
  localparam int T   = erm_pkg::TRIG_BITS;
  localparam int TW  = erm_pkg::TRIG_W;
  localparam int VW  = erm_pkg::VEC_W;
  localparam int PW  = erm_pkg::PROD_W;
  localparam int WW  = erm_pkg::WIDE_W;
  localparam int QW  = erm_pkg::QUO_W;
  localparam int DW  = erm_pkg::DIV_W;
  localparam int CRW = erm_pkg::CR_W;
  localparam int MW  = erm_pkg::MAG_W;

  typedef struct packed {
    logic                 mode;
    logic                 sing;
    logic                 qneg;
    logic [DW-1:0]        dmag;
    logic [QW-1:0]        dq;
    logic [DW-1:0]        rem;
    logic signed [TW-1:0] spit;
    logic signed [VW-1:0] c;
    logic signed [VW-1:0] x1;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] z1;
    logic                 sat_e;
  } div_t;

  logic adv;
  logic v1, v2, v3, v5, v6, v7;
  logic [QW:0] dv;

  // stage 1
  logic s1_mode, s1_sing;
  logic signed [PW-1:0] s1_p1, s1_p2, s1_p3, s1_p4, s1_p5, s1_p6;
  logic signed [VW-1:0] s1_c;
  logic signed [TW-1:0] s1_spit, s1_cpit, s1_syaw, s1_cyaw;
  // stage 2
  logic s2_mode, s2_sing;
  logic signed [PW:0]    s2_num, s2_ny, s2_z1;
  logic signed [CRW-1:0] s2_cr;
  logic signed [PW-1:0]  s2_p2, s2_p3;
  logic signed [VW-1:0]  s2_c;
  logic signed [TW-1:0]  s2_spit, s2_cpit, s2_syaw, s2_cyaw;
  // stage 3
  logic s3_mode, s3_sing, s3_qneg;
  logic signed [TW+CRW-1:0] s3_m1, s3_m2;
  erm_pkg::clamp_t s3_ry0, s3_rz1;
  logic [QW-1:0] s3_nmag;
  logic [DW-1:0] s3_dmag;
  logic signed [PW-1:0] s3_p2, s3_p3;
  logic signed [VW-1:0] s3_c;
  logic signed [TW-1:0] s3_spit;
  // stage 4 and the divider
  erm_pkg::clamp_t rx1, ry1;
  div_t div [QW+1];
  // stage 5
  logic s5_mode, s5_sing, s5_negp;
  erm_pkg::clamp_t s5_rx0;
  logic [2*DW-1:0]    s5_phi;
  logic [32+DW-1:0]   s5_plo;
  logic signed [VW-1:0] s5_c, s5_x1, s5_y, s5_z1;
  logic s5_sat_e;
  logic [QW-1:0] mf;
  logic [DW-1:0] ms;
  logic signed [WW-1:0] fac;
  // stage 6
  logic s6_mode, s6_sing, s6_negp, s6_ovf, s6_sat_e, s6_sat_x;
  logic signed [WW-1:0] s6_prod;
  logic signed [VW-1:0] s6_c, s6_x, s6_y, s6_z1;
  logic [MW-1:0] mag;
  // output stage
  logic o_mode, o_sing, o_sat;
  logic signed [VW-1:0] o_x, o_y, o_z;
  erm_pkg::clamp_t rz0;

  assign adv     = !v7 || rsp.ready;
  assign q_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      dv <= '0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (adv) begin
      v1 <= q_valid;
      v2 <= v1;
      v3 <= v2;
      dv <= {dv[QW-1:0], v3};
      v5 <= dv[QW];
      v6 <= v5;
      v7 <= v6;
    end
  end

  // stage 1: all trig-by-vector products
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mode <= q.mode;
      s1_sing <= q.sing;
      s1_p1   <= PW'(q.c_yaw) * PW'(q.a);
      s1_p2   <= PW'(q.s_yaw) * PW'(q.b);
      s1_p3   <= PW'(q.c_yaw) * PW'(q.b);
      s1_p4   <= PW'(q.s_yaw) * PW'(q.a);
      s1_p5   <= PW'(q.c_pit) * PW'(q.a);
      s1_p6   <= PW'(q.s_pit) * PW'(q.a);
      s1_c    <= q.c;
      s1_spit <= q.s_pit;
      s1_cpit <= q.c_pit;
      s1_syaw <= q.s_yaw;
      s1_cyaw <= q.c_yaw;
    end
  end

  // stage 2: combine products
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_mode <= s1_mode;
      s2_sing <= s1_sing;
      s2_num  <= (PW+1)'(s1_p1) + (PW+1)'(s1_p2);
      s2_ny   <= (PW+1)'(s1_p3) - (PW+1)'(s1_p4);
      s2_cr   <= CRW'(erm_pkg::round_q(WW'(s1_p5)));
      s2_z1   <= ((PW+1)'(s1_c) <<< T) - (PW+1)'(s1_p6);
      s2_p2   <= s1_p2;
      s2_p3   <= s1_p3;
      s2_c    <= s1_c;
      s2_spit <= s1_spit;
      s2_cpit <= s1_cpit;
      s2_syaw <= s1_syaw;
      s2_cyaw <= s1_cyaw;
    end
  end

  // stage 3: second products, early rounding, divider operands
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_mode <= s2_mode;
      s3_sing <= s2_sing;
      s3_m1   <= (TW+CRW)'(s2_cyaw) * (TW+CRW)'(s2_cr);
      s3_m2   <= (TW+CRW)'(s2_syaw) * (TW+CRW)'(s2_cr);
      s3_ry0  <= erm_pkg::clamp32(erm_pkg::round_q(WW'(s2_ny)));
      s3_rz1  <= erm_pkg::clamp32(erm_pkg::round_q(WW'(s2_z1)));
      s3_nmag <= QW'(s2_num[PW] ? -s2_num : s2_num);
      s3_dmag <= DW'(s2_cpit[TW-1] ? -s2_cpit : s2_cpit);
      s3_qneg <= s2_num[PW] ^ s2_cpit[TW-1];
      s3_p2   <= s2_p2;
      s3_p3   <= s2_p3;
      s3_c    <= s2_c;
      s3_spit <= s2_spit;
    end
  end

  // stage 4: finish mode 1, load the divider
  always_comb begin
    rx1 = erm_pkg::clamp32(erm_pkg::round_q(WW'(s3_m1) - WW'(s3_p2)));
    ry1 = erm_pkg::clamp32(erm_pkg::round_q(WW'(s3_m2) + WW'(s3_p3)));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div[0].mode  <= s3_mode;
      div[0].sing  <= s3_sing;
      div[0].qneg  <= s3_qneg;
      div[0].dmag  <= s3_dmag;
      div[0].dq    <= s3_nmag;
      div[0].rem   <= '0;
      div[0].spit  <= s3_spit;
      div[0].c     <= s3_c;
      div[0].x1    <= rx1.v;
      div[0].y     <= s3_mode ? ry1.v : s3_ry0.v;
      div[0].z1    <= s3_rz1.v;
      div[0].sat_e <= s3_mode ? (rx1.sat || ry1.sat || s3_rz1.sat) : s3_ry0.sat;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [DW:0] trial, diff;
    div_t        div_next;
    always_comb begin
      trial    = {div[k].rem, div[k].dq[QW-1]};
      diff     = trial - {1'b0, div[k].dmag};
      div_next = div[k];
      if (!diff[DW]) begin
        div_next.rem = diff[DW-1:0];
        div_next.dq  = {div[k].dq[QW-2:0], 1'b1};
      end else begin
        div_next.rem = trial[DW-1:0];
        div_next.dq  = {div[k].dq[QW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        div[k+1] <= div_next;
      end
    end
  end

  // stage 5: roll rate clamp, partial products of sin(pitch) * rate
  always_comb begin
    mf  = div[QW].dq;
    ms  = DW'(div[QW].spit[TW-1] ? -div[QW].spit : div[QW].spit);
    fac = div[QW].qneg ? -WW'(mf) : WW'(mf);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_mode  <= div[QW].mode;
      s5_sing  <= div[QW].sing;
      s5_negp  <= div[QW].qneg ^ div[QW].spit[TW-1];
      s5_rx0   <= erm_pkg::clamp32(fac);
      s5_phi   <= (2*DW)'(mf[QW-1:32]) * (2*DW)'(ms);
      s5_plo   <= (32+DW)'(mf[31:0]) * (32+DW)'(ms);
      s5_c     <= div[QW].c;
      s5_x1    <= div[QW].x1;
      s5_y     <= div[QW].y;
      s5_z1    <= div[QW].z1;
      s5_sat_e <= div[QW].sat_e;
    end
  end

  // stage 6: join partial products, apply the sign
  always_comb begin
    mag = (MW'(s5_phi[T-1:0]) << 32) + MW'(s5_plo);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_mode  <= s5_mode;
      s6_sing  <= s5_sing;
      s6_negp  <= s5_negp;
      s6_ovf   <= s5_phi[2*DW-1:T] != '0;
      s6_prod  <= s5_negp ? -WW'(mag) : WW'(mag);
      s6_c     <= s5_c;
      s6_x     <= s5_mode ? s5_x1 : s5_rx0.v;
      s6_sat_x <= s5_mode ? 1'b0 : s5_rx0.sat;
      s6_y     <= s5_y;
      s6_z1    <= s5_z1;
      s6_sat_e <= s5_sat_e;
    end
  end

  // output stage: yaw rate, singular override
  always_comb begin
    rz0 = erm_pkg::clamp32(erm_pkg::round_q(s6_prod + (WW'(s6_c) <<< T)));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_mode <= s6_mode;
      if (s6_mode) begin
        o_x    <= s6_x;
        o_y    <= s6_y;
        o_z    <= s6_z1;
        o_sing <= 1'b0;
        o_sat  <= s6_sat_e;
      end else if (s6_sing) begin
        o_x    <= '0;
        o_y    <= '0;
        o_z    <= '0;
        o_sing <= 1'b1;
        o_sat  <= 1'b0;
      end else begin
        o_x    <= s6_x;
        o_y    <= s6_y;
        o_sing <= 1'b0;
        if (s6_ovf) begin
          o_z   <= s6_negp ? erm_pkg::VEC_NEG_MAX : erm_pkg::VEC_POS_MAX;
          o_sat <= 1'b1;
        end else begin
          o_z   <= rz0.v;
          o_sat <= s6_sat_x || s6_sat_e || rz0.sat;
        end
      end
    end
  end

  assign rsp.valid     = v7;
  assign rsp.out_x     = o_x;
  assign rsp.out_y     = o_y;
  assign rsp.out_z     = o_z;
  assign rsp.singular  = o_sing;
  assign rsp.saturated = o_sat;

  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    v7 && o_sing |-> o_x == '0 && o_y == '0 && o_z == '0 && !o_sat)
    else $error("singular result carries data");

  a_mode1_not_sing: assert property (@(posedge clk) disable iff (rst)
    v7 && o_mode |-> !o_sing)
    else $error("mode 1 result flagged singular");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    dv[QW] && !div[QW].mode && !div[QW].sing |-> div[QW].rem < div[QW].dmag)
    else $error("divider remainder not below divisor");
endmodule

### sim/testbench.sv
module testbench;
  // Local copies of the package constants
  localparam int TRIG_BITS    = erm_pkg::TRIG_BITS;
  localparam int ANGLE_W      = erm_pkg::ANGLE_W;
  localparam int VEC_W        = erm_pkg::VEC_W;
  localparam int LIMIT_W      = erm_pkg::LIMIT_W;
  localparam int CORDIC_STEPS = erm_pkg::CORDIC_STEPS;
  localparam int CORDIC_FRAC  = erm_pkg::CORDIC_FRAC;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = erm_pkg::LIMIT_RESET;
  localparam logic signed [erm_pkg::CORDIC_W-1:0] CORDIC_GAIN = erm_pkg::CORDIC_GAIN;
  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = erm_pkg::ATAN_TURNS;
  localparam logic signed [VEC_W-1:0] VEC_POS_MAX = erm_pkg::VEC_POS_MAX;
  localparam logic signed [VEC_W-1:0] VEC_NEG_MAX = erm_pkg::VEC_NEG_MAX;

  // Flush allowance after the last result
  localparam int DRAIN_CYCLES = 4 * (TRIG_BITS + 73);
  // Cycles with no transaction on any channel before the run is declared hung
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 170;

  typedef struct {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
    logic                    singular;
    logic                    saturated;
  } rate_result_t;

  logic clk;
  logic rst;

  erm_in_if  cmd ();
  erm_out_if rsp ();
  erm_cfg_if cfg ();

  euler_rpy_rate_map i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp),
    .cfg (cfg)
  );

  // Predictor copy of the threshold register
  logic [LIMIT_W-1:0] cos_limit;
  rate_result_t       pending_rates[$];
  int                 mismatch_cnt;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sine and cosine of a binary angle in Q(TRIG_BITS), via a 30-step rotation CORDIC.
  // Angles in the left half plane are turned by half a turn first and negated after.
  function automatic void cordic_sincos(input logic [ANGLE_W-1:0] ang,
                                        output longint sn, output longint cs);
    logic [31:0] ph;
    logic [31:0] probe;
    bit          flip;
    longint      x;
    longint      y;
    longint      z;
    longint      nx;
    longint      one;
    ph    = {ang, 16'h0000};
    probe = ph + 32'h4000_0000;
    flip  = probe[31];
    if (flip) ph = ph + 32'h8000_0000;
    z   = longint'($signed(ph));
    x   = longint'(CORDIC_GAIN);
    y   = 0;
    one = longint'(1) <<< TRIG_BITS;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(ATAN_TURNS[i]);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(ATAN_TURNS[i]);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    x = (x + (longint'(1) <<< (CORDIC_FRAC - TRIG_BITS - 1))) >>> (CORDIC_FRAC - TRIG_BITS);
    y = (y + (longint'(1) <<< (CORDIC_FRAC - TRIG_BITS - 1))) >>> (CORDIC_FRAC - TRIG_BITS);
    if (x > one) x = one;
    if (x < -one) x = -one;
    if (y > one) y = one;
    if (y < -one) y = -one;
    cs = x;
    sn = y;
  endfunction

  // Drop TRIG_BITS fraction bits with round half up
  function automatic longint rescale(input longint v);
    return (v + (longint'(1) <<< (TRIG_BITS - 1))) >>> TRIG_BITS;
  endfunction

  function automatic logic signed [VEC_W-1:0] clip32(input longint v, inout bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return VEC_POS_MAX;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return VEC_NEG_MAX;
    end
    return v[VEC_W-1:0];
  endfunction

  function automatic rate_result_t compute_rate_map(
    input logic mode, input logic [ANGLE_W-1:0] pitch, input logic [ANGLE_W-1:0] yaw,
    input logic signed [VEC_W-1:0] vx, input logic signed [VEC_W-1:0] vy,
    input logic signed [VEC_W-1:0] vz);
    longint          sp;
    longint          cp;
    longint          sy;
    longint          cy;
    longint          a;
    longint          b;
    longint          c;
    longint          mag;
    longint          fac;
    longint          prod;
    longint          cr;
    longint unsigned mf;
    longint unsigned ms;
    longint unsigned phi;
    longint unsigned plo;
    bit              negp;
    bit              sat;
    rate_result_t    r;
    cordic_sincos(pitch, sp, cp);
    cordic_sincos(yaw, sy, cy);
    a   = vx;
    b   = vy;
    c   = vz;
    sat = 1'b0;
    r   = '{x: '0, y: '0, z: '0, singular: 1'b0, saturated: 1'b0};
    if (mode == 1'b0) begin
      mag = (cp < 0) ? -cp : cp;
      if (cp == 0 || (mag <<< 15) < (longint'(cos_limit) <<< TRIG_BITS)) begin
        r.singular = 1'b1;
        return r;
      end
      // Roll rate: exact numerator over cos(pitch), truncated toward zero
      fac  = (cy * a + sy * b) / cp;
      mf   = (fac < 0) ? longint'(-fac) : longint'(fac);
      ms   = (sp < 0) ? longint'(-sp) : longint'(sp);
      phi  = (mf >> 32) * ms;
      plo  = (mf & 64'hFFFF_FFFF) * ms;
      negp = (fac < 0) != (sp < 0);
      r.x  = clip32(fac, sat);
      r.y  = clip32(rescale(cy * b - sy * a), sat);
      // Yaw rate uses the wide roll rate; a product of 2^(TRIG_BITS+32) or more pins the output
      if (phi >= (64'd1 << TRIG_BITS)) begin
        sat = 1'b1;
        r.z = negp ? VEC_NEG_MAX : VEC_POS_MAX;
      end else begin
        prod = longint'((phi << 32) + plo);
        if (negp) prod = -prod;
        r.z = clip32(rescale(prod + (c <<< TRIG_BITS)), sat);
      end
    end else begin
      cr  = rescale(cp * a);
      r.x = clip32(rescale(cy * cr - sy * b), sat);
      r.y = clip32(rescale(sy * cr + cy * b), sat);
      r.z = clip32(rescale((c <<< TRIG_BITS) - sp * a), sat);
    end
    r.saturated = sat;
    return r;
  endfunction

  // Send one transaction; the expectation is queued at the accepting edge
  task automatic send_rate_item(input logic mode, input logic [ANGLE_W-1:0] pitch,
                                input logic [ANGLE_W-1:0] yaw,
                                input logic signed [VEC_W-1:0] vx,
                                input logic signed [VEC_W-1:0] vy,
                                input logic signed [VEC_W-1:0] vz);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid       <= 1'b1;
    cmd.mode        <= mode;
    cmd.pitch_angle <= pitch;
    cmd.yaw_angle   <= yaw;
    cmd.in_x        <= vx;
    cmd.in_y        <= vy;
    cmd.in_z        <= vz;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    pending_rates.push_back(compute_rate_map(mode, pitch, yaw, vx, vy, vz));
  endtask

  task automatic release_cmd();
    cmd.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Write the threshold only with the pipeline empty
  task automatic write_cos_limit(input logic [LIMIT_W-1:0] limit);
    while (pending_rates.size() != 0) @(posedge clk);
    repeat (TRIG_BITS + 80) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= limit;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cos_limit = limit;
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [VEC_W-1:0] rand_vec();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? VEC_POS_MAX : VEC_NEG_MAX;
      1: return $signed(32'($urandom_range(131071)) - 32'sd65536);
      2: return $signed(32'($urandom_range(2097151)) - 32'sd1048576);
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic logic [ANGLE_W-1:0] rand_angle();
    // Bias some angles near the quarter turns, where the divide gets large
    if ($urandom_range(3) == 0)
      return ANGLE_W'(($urandom_range(1) ? 16384 : 49152) + $urandom_range(64) - 32);
    return ANGLE_W'($urandom());
  endfunction

  // Extremes of every field, both modes, and the singular, zero-cosine,
  // clamped and pinned yaw-rate cases
  task automatic test_directed();
    write_cos_limit('0);
    send_rate_item(1'b0, 16'd0, 16'd0, 32'sd65536, 32'sd131072, -32'sd65536);
    send_rate_item(1'b1, 16'd0, 16'd0, 32'sd65536, 32'sd131072, -32'sd65536);
    send_rate_item(1'b0, 16'd16384, 16'd0, 32'sd65536, 32'sd0, 32'sd0);
    send_rate_item(1'b0, 16'd49152, 16'd8192, 32'sd65536, 32'sd65536, 32'sd0);
    send_rate_item(1'b0, 16'd16383, 16'd0, VEC_POS_MAX, VEC_POS_MAX, VEC_NEG_MAX);
    send_rate_item(1'b0, 16'd16385, 16'd0, VEC_NEG_MAX, VEC_NEG_MAX, VEC_POS_MAX);
    send_rate_item(1'b0, 16'd49153, 16'd65535, VEC_POS_MAX, 32'sd0, VEC_POS_MAX);
    send_rate_item(1'b0, 16'd32768, 16'd32768, VEC_NEG_MAX, VEC_POS_MAX, -32'sd1);
    send_rate_item(1'b1, 16'd65535, 16'd65535, VEC_NEG_MAX, VEC_NEG_MAX, VEC_NEG_MAX);
    send_rate_item(1'b1, 16'd32768, 16'd16384, VEC_POS_MAX, VEC_POS_MAX, VEC_POS_MAX);
    send_rate_item(1'b1, 16'd16384, 16'd49152, VEC_POS_MAX, VEC_NEG_MAX, VEC_NEG_MAX);
    send_rate_item(1'b1, 16'd8192, 16'd24576, -32'sd1, 32'sd1, 32'sd0);
    send_rate_item(1'b0, 16'd4000, 16'd60000, -32'sd1, 32'sd1, 32'sd0);
    send_rate_item(1'b0, 16'd0, 16'd0, 32'sd0, 32'sd0, 32'sd0);
    release_cmd();
    write_cos_limit(LIMIT_W'(33));
    send_rate_item(1'b0, 16'd16383, 16'd0, 32'sd65536, 32'sd0, 32'sd0);
    send_rate_item(1'b0, 16'd16370, 16'd0, 32'sd65536, 32'sd0, 32'sd0);
    send_rate_item(1'b1, 16'd16384, 16'd0, 32'sd65536, 32'sd65536, 32'sd65536);
    release_cmd();
    write_cos_limit({LIMIT_W{1'b1}});
    send_rate_item(1'b0, 16'd0, 16'd0, 32'sd65536, 32'sd65536, 32'sd65536);
    send_rate_item(1'b0, 16'd1, 16'd0, 32'sd65536, 32'sd65536, 32'sd65536);
    send_rate_item(1'b0, 16'd32768, 16'd0, 32'sd65536, 32'sd65536, 32'sd65536);
    release_cmd();
  endtask

  task automatic test_random(input logic [LIMIT_W-1:0] limit, input int snd_pct,
                             input int rcv_pct);
    write_cos_limit(limit);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    for (int n = 0; n < RANDOM_ITEMS; n++)
      send_rate_item(1'($urandom()), rand_angle(), rand_angle(), rand_vec(), rand_vec(),
                     rand_vec());
    release_cmd();
  endtask

  // Receiver: stall at random at the current idle rate
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_rates.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time, rsp.out_x,
                 rsp.out_y, rsp.out_z);
      end else begin
        rate_result_t exp_r;
        exp_r = pending_rates.pop_front();
        if (rsp.out_x !== exp_r.x || rsp.out_y !== exp_r.y || rsp.out_z !== exp_r.z ||
            rsp.singular !== exp_r.singular || rsp.saturated !== exp_r.saturated) begin
          mismatch_cnt++;
          $display("%0t: expected x=%0d y=%0d z=%0d sing=%b sat=%b", $time, exp_r.x,
                   exp_r.y, exp_r.z, exp_r.singular, exp_r.saturated);
          $display("%0t: actual   x=%0d y=%0d z=%0d sing=%b sat=%b", $time, rsp.out_x,
                   rsp.out_y, rsp.out_z, rsp.singular, rsp.saturated);
        end
      end
    end
  end

  // Watchdog: advance on quiet cycles, clear on any transaction
  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    mismatch_cnt    = 0;
    quiet_cycles    = 0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    cos_limit       = LIMIT_RESET;
    rst             = 1'b1;
    cmd.valid       = 1'b0;
    cmd.mode        = 1'b0;
    cmd.pitch_angle = '0;
    cmd.yaw_angle   = '0;
    cmd.in_x        = '0;
    cmd.in_y        = '0;
    cmd.in_z        = '0;
    cfg.valid       = 1'b0;
    cfg.data        = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(LIMIT_W'(33), 10, 81);
    test_random({LIMIT_W{1'b1}}, 81, 10);
    test_random(LIMIT_W'($urandom_range(4000)), 0, 0);

    // Hold until every result is in, then let the pipeline flush
    while (pending_rates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
